/* rtl/socks5_handshake_message_checker_assert.svh */
// ----------------------------------------------------------------------------
// SOCKS5 handshake checker assertion macros
// Shared macros for the concurrent assertions of the checker, clocked on clk
// and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SOCKS5_HANDSHAKE_MESSAGE_CHECKER_ASSERT_SVH
`define SOCKS5_HANDSHAKE_MESSAGE_CHECKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHMC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent sequence starts in the cycle after the antecedent.
`define SHMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error(msg);

`endif

/* rtl/socks5hmc_pkg.sv */
// ----------------------------------------------------------------------------
// SOCKS5 handshake checker package
// Register map, protocol constants and the structs passed between modules.
// ----------------------------------------------------------------------------
package socks5hmc_pkg;

	localparam int COUNT_BITS_DEF = 9;
	localparam int CFG_ADDR_BITS  = 5;
	localparam int CFG_DATA_BITS  = 32;
	localparam int LEN_BITS       = 9;

	localparam logic [2:0] REG_METHOD_LEN_MIN  = 3'd0;
	localparam logic [2:0] REG_METHOD_LEN_MAX  = 3'd1;
	localparam logic [2:0] REG_REQUEST_LEN_MIN = 3'd2;
	localparam logic [2:0] REG_REQUEST_LEN_MAX = 3'd3;
	localparam logic [2:0] REG_WANTED_METHOD   = 3'd4;

	localparam logic [LEN_BITS-1:0] METHOD_LEN_MIN_RST  = 9'd3;
	localparam logic [LEN_BITS-1:0] METHOD_LEN_MAX_RST  = 9'd257;
	localparam logic [LEN_BITS-1:0] REQUEST_LEN_MIN_RST = 9'd7;
	localparam logic [LEN_BITS-1:0] REQUEST_LEN_MAX_RST = 9'd262;
	localparam logic [7:0]          WANTED_METHOD_RST   = 8'd0;

	localparam logic [1:0] KIND_METHOD  = 2'd0;
	localparam logic [1:0] KIND_CONNECT = 2'd1;

	localparam logic [7:0] SOCKS_VERSION = 8'd5;
	localparam logic [7:0] CMD_MIN       = 8'h01;
	localparam logic [7:0] CMD_MAX       = 8'h03;
	localparam logic [7:0] ATYP_IPV4     = 8'h01;
	localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
	localparam logic [7:0] ATYP_IPV6     = 8'h04;

	localparam int LEN_IPV4        = 10;
	localparam int LEN_IPV6        = 22;
	localparam int LEN_DOMAIN_BASE = 7;
	localparam int METHOD_HDR_LEN  = 2;

	typedef struct packed {
		logic [LEN_BITS-1:0] method_len_min;
		logic [LEN_BITS-1:0] method_len_max;
		logic [LEN_BITS-1:0] request_len_min;
		logic [LEN_BITS-1:0] request_len_max;
		logic [7:0]          wanted_method;
	} cfg_t;

	typedef struct packed {
		logic message_valid;
		logic method_found;
	} res_t;

endpackage

/* rtl/socks5hmc_regs.sv */
// ----------------------------------------------------------------------------
// SOCKS5 handshake checker configuration registers
// APB-style register file holding the length bounds and the wanted method.
// ----------------------------------------------------------------------------
module socks5hmc_regs
	import socks5hmc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [CFG_DATA_BITS-1:0] pwdata,
	output logic [CFG_DATA_BITS-1:0] prdata,
	output logic                     pready,
	output cfg_t                     cfg
);

	cfg_t       cfg_q;
	logic [2:0] reg_index;
	logic       wr_en;

	assign reg_index = paddr[CFG_ADDR_BITS-1:2];
	assign wr_en     = psel && penable && pwrite;
	assign pready    = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.method_len_min  <= METHOD_LEN_MIN_RST;
			cfg_q.method_len_max  <= METHOD_LEN_MAX_RST;
			cfg_q.request_len_min <= REQUEST_LEN_MIN_RST;
			cfg_q.request_len_max <= REQUEST_LEN_MAX_RST;
			cfg_q.wanted_method   <= WANTED_METHOD_RST;
		end else if (wr_en) begin
			case (reg_index)
				REG_METHOD_LEN_MIN:  cfg_q.method_len_min  <= pwdata[LEN_BITS-1:0];
				REG_METHOD_LEN_MAX:  cfg_q.method_len_max  <= pwdata[LEN_BITS-1:0];
				REG_REQUEST_LEN_MIN: cfg_q.request_len_min <= pwdata[LEN_BITS-1:0];
				REG_REQUEST_LEN_MAX: cfg_q.request_len_max <= pwdata[LEN_BITS-1:0];
				REG_WANTED_METHOD:   cfg_q.wanted_method   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_index)
			REG_METHOD_LEN_MIN:  prdata = CFG_DATA_BITS'(cfg_q.method_len_min);
			REG_METHOD_LEN_MAX:  prdata = CFG_DATA_BITS'(cfg_q.method_len_max);
			REG_REQUEST_LEN_MIN: prdata = CFG_DATA_BITS'(cfg_q.request_len_min);
			REG_REQUEST_LEN_MAX: prdata = CFG_DATA_BITS'(cfg_q.request_len_max);
			REG_WANTED_METHOD:   prdata = CFG_DATA_BITS'(cfg_q.wanted_method);
			default:             prdata = '0;
		endcase
	end

endmodule

/* rtl/socks5hmc_core.sv */
// ----------------------------------------------------------------------------
// SOCKS5 handshake checker byte stage
// Registers each incoming beat, updates the per-message field state and
// evaluates the final checks when the last byte of a message is processed.
// ----------------------------------------------------------------------------
module socks5hmc_core
	import socks5hmc_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] message_kind,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       out_ready,
	output logic       res_valid,
	output res_t       res
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic                  valid_s1;
	logic [1:0]            kind_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;

	logic [COUNT_BITS-1:0] byte_count_q;
	logic                  field_ok_q;
	logic [7:0]            list_count_q;
	logic [7:0]            addr_type_q;
	logic [7:0]            name_length_q;
	logic                  match_seen_q;

	logic                  field_ok_n;
	logic [7:0]            list_count_n;
	logic [7:0]            addr_type_n;
	logic [7:0]            name_length_n;
	logic                  match_seen_n;
	logic                  at_new;
	logic [COUNT_BITS-1:0] len;
	logic                  fit;
	logic                  fire;
	logic                  load;

	assign fire      = valid_s1 && (!last_s1 || out_ready);
	assign in_stall  = valid_s1 && !fire;
	assign load      = in_valid && !in_stall;
	assign res_valid = fire && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_s1 <= message_kind;
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_comb begin
		at_new        = byte_count_q != CNT_MAX;
		len           = at_new ? byte_count_q + COUNT_BITS'(1) : byte_count_q;
		field_ok_n    = field_ok_q;
		list_count_n  = list_count_q;
		addr_type_n   = addr_type_q;
		name_length_n = name_length_q;
		match_seen_n  = match_seen_q;
		case (kind_s1)
			KIND_METHOD: begin
				if (at_new) begin
					if (byte_count_q == COUNT_BITS'(0) && byte_s1 != SOCKS_VERSION) begin
						field_ok_n = 1'b0;
					end else if (byte_count_q == COUNT_BITS'(1)) begin
						list_count_n = byte_s1;
					end else if (byte_count_q >= COUNT_BITS'(METHOD_HDR_LEN) &&
							(byte_count_q - COUNT_BITS'(METHOD_HDR_LEN)) <
							COUNT_BITS'(list_count_q) &&
							byte_s1 == cfg.wanted_method) begin
						match_seen_n = 1'b1;
					end
				end
			end
			KIND_CONNECT: begin
				if (at_new) begin
					if (byte_count_q == COUNT_BITS'(0) && byte_s1 != SOCKS_VERSION) begin
						field_ok_n = 1'b0;
					end else if (byte_count_q == COUNT_BITS'(1) &&
							!(byte_s1 inside {[CMD_MIN:CMD_MAX]})) begin
						field_ok_n = 1'b0;
					end else if (byte_count_q == COUNT_BITS'(2) && byte_s1 != 8'd0) begin
						field_ok_n = 1'b0;
					end else if (byte_count_q == COUNT_BITS'(3)) begin
						addr_type_n = byte_s1;
					end else if (byte_count_q == COUNT_BITS'(4)) begin
						name_length_n = byte_s1;
					end
				end
			end
			default: begin
				field_ok_n = 1'b0;
			end
		endcase

		case (addr_type_n)
			ATYP_IPV4:   fit = len == COUNT_BITS'(LEN_IPV4);
			ATYP_IPV6:   fit = len == COUNT_BITS'(LEN_IPV6);
			ATYP_DOMAIN: fit = len == COUNT_BITS'(LEN_DOMAIN_BASE) + COUNT_BITS'(name_length_n);
			default:     fit = 1'b0;
		endcase

		res = '0;
		case (kind_s1)
			KIND_METHOD: begin
				res.message_valid = field_ok_n &&
					len >= COUNT_BITS'(cfg.method_len_min) &&
					len <= COUNT_BITS'(cfg.method_len_max) &&
					len >= COUNT_BITS'(METHOD_HDR_LEN) &&
					COUNT_BITS'(list_count_n) == len - COUNT_BITS'(METHOD_HDR_LEN);
				res.method_found = match_seen_n;
			end
			KIND_CONNECT: begin
				res.message_valid = field_ok_n && fit &&
					len >= COUNT_BITS'(cfg.request_len_min) &&
					len <= COUNT_BITS'(cfg.request_len_max);
			end
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			field_ok_q    <= 1'b1;
			list_count_q  <= '0;
			addr_type_q   <= '0;
			name_length_q <= '0;
			match_seen_q  <= 1'b0;
		end else if (fire) begin
			if (last_s1) begin
				byte_count_q  <= '0;
				field_ok_q    <= 1'b1;
				list_count_q  <= '0;
				addr_type_q   <= '0;
				name_length_q <= '0;
				match_seen_q  <= 1'b0;
			end else begin
				byte_count_q  <= len;
				field_ok_q    <= field_ok_n;
				list_count_q  <= list_count_n;
				addr_type_q   <= addr_type_n;
				name_length_q <= name_length_n;
				match_seen_q  <= match_seen_n;
			end
		end
	end

endmodule

/* rtl/socks5hmc_out.sv */
// ----------------------------------------------------------------------------
// SOCKS5 handshake checker result register
// Holds one verdict beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module socks5hmc_out
	import socks5hmc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic res_valid,
	input  res_t res,
	output logic out_ready,
	output logic out_valid,
	input  logic out_stall,
	output logic message_valid,
	output logic method_found
);

	logic out_valid_q;
	res_t res_q;

	assign out_ready     = !out_valid_q || !out_stall;
	assign out_valid     = out_valid_q;
	assign message_valid = res_q.message_valid;
	assign method_found  = res_q.method_found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

endmodule

/* rtl/socks5_handshake_message_checker.sv */
// A verdict leaves the byte stage with the last byte, then waits in the result register.
// Throughput: one byte per cycle while not stalled; each byte passes the byte stage once.
// A byte is refused only while the last byte of a message waits behind a stalled verdict.
// Reset clears the message state, the pipeline valids and loads the default register values.
// ----------------------------------------------------------------------------
// SOCKS5 handshake message checker
// Checks method and connect requests byte by byte and reports one verdict
// beat per message, with a flag for the configured authentication method.
// ----------------------------------------------------------------------------
module socks5_handshake_message_checker
	import socks5hmc_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [CFG_DATA_BITS-1:0] pwdata,
	output logic [CFG_DATA_BITS-1:0] prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               message_kind,
	input  logic [7:0]               data_byte,
	input  logic                     last_byte,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     message_valid,
	output logic                     method_found
);

`include "socks5_handshake_message_checker_assert.svh"

	cfg_t cfg;
	res_t res;
	logic res_valid;
	logic out_ready;

	socks5hmc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	socks5hmc_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.message_kind (message_kind),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_ready    (out_ready),
		.res_valid    (res_valid),
		.res          (res)
	);

	socks5hmc_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_valid     (res_valid),
		.res           (res),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.message_valid (message_valid),
		.method_found  (method_found)
	);

	`SHMC_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a blocked verdict")
	`SHMC_ASSERT_NEXT(a_verdict_due, in_valid && !in_stall && last_byte, ##1 out_valid, "no verdict two cycles after a last byte")
	`SHMC_ASSERT_SAME(a_verdict_slot, res_valid, out_ready, "verdict produced while the result register is full")

endmodule
